[sv/twid_pkg.sv]
package twid_pkg;

    // Table sizes
    localparam int MAX_NODES   = 1024;
    localparam int ALPHABET    = 26;
    localparam int MAX_DEPTH   = 32;
    localparam int ID_W        = $clog2(MAX_NODES + 1);
    localparam int NODE_AW     = $clog2(MAX_NODES);
    localparam int LVL_W       = $clog2(MAX_DEPTH + 2);
    localparam int CHILD_DEPTH = (MAX_NODES + 1) * ALPHABET;
    localparam int CHILD_AW    = $clog2(CHILD_DEPTH);
    localparam int MARK_DEPTH  = MAX_NODES + 1;
    localparam int MARK_AW     = $clog2(MARK_DEPTH);
    localparam int LETTER_W    = 5;
    localparam int INFO_W      = LVL_W + ID_W + LETTER_W;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_BAD_CHAR  = 3'd3,
        ST_BAD_ID    = 3'd4,
        ST_TOO_LONG  = 3'd5
    } t_status;

    // Sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_C_RD,
        S_C_EVAL,
        S_M_RD,
        S_M_EVAL,
        S_G_RD,
        S_G_EVAL,
        S_OUT
    } t_state;

endpackage

[sv/trie_word_id_dictionary.sv]
// Trie dictionary of lower-case words with dense node ids. Words arrive one
// character per beat (tlast on the final character, tuser[1] selects insert);
// a beat with tuser[0] set asks for the word that ends at a node id and is
// answered with one beat per letter, last letter first. The block handles one
// request at a time. A character that extends the walk is accepted, then the
// child table is read and updated. A character of a word that has already
// failed or grown too long is only accepted. A final character is walked the
// same way when it can be, then its word-end mark is read and updated before
// its output beat. A get-word request is accepted, then each letter takes one
// read of the node-information memory and that letter's output beat. After
// reset the child table and the word-end marks are cleared in a pass over the
// 26650 child-table entries, during which no beat is accepted.
module trie_word_id_dictionary (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // char_byte [7:0], word_id [17:8], zero fill
    input  logic        i_s_tlast,   // last_char
    input  logic [1:0]  i_s_tuser,   // req_type [0], insert_mode [1]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // node_id [9:0], letter [16:10], letter_pos [21:17]
    output logic        o_m_tlast,   // last_out
    output logic [2:0]  o_m_tuser    // status
);
    import twid_pkg::*;

    t_state r_state, n_state;

    logic [ID_W-1:0]     r_count;
    logic [ID_W-1:0]     r_pos;
    logic [1:0]          r_failed;
    logic [LVL_W-1:0]    r_cidx;
    logic [CHILD_AW-1:0] r_clr;
    logic [LETTER_W-1:0] r_j;
    logic                r_last;
    logic                r_ins;
    logic [ID_W-1:0]     r_n;
    logic [CHILD_AW-1:0] r_slot;

    logic [2:0]          r_status;
    logic [9:0]          r_id;
    logic [6:0]          r_letter;
    logic [4:0]          r_lpos;
    logic                r_olast;

    // RAM ports
    logic                c_we, m_we, i_we_info;
    logic [CHILD_AW-1:0] c_waddr, c_raddr;
    logic [ID_W-1:0]     c_wdata, c_rdata;
    logic [MARK_AW-1:0]  m_waddr;
    logic                m_wdata, m_rdata;
    logic [INFO_W-1:0]   info_wdata, info_rdata;
    logic [NODE_AW-1:0]  info_raddr;

    // Input decode and case folding
    logic       accept;
    logic [7:0] ch, fch;
    logic       is_letter;
    logic [9:0] wid;
    assign accept    = i_s_tvalid && o_s_tready;
    assign ch        = i_s_tdata[7:0];
    assign wid       = i_s_tdata[17:8];
    assign fch       = (ch >= 8'h41 && ch <= 8'h5a) ? ch + 8'd32 : ch;
    assign is_letter = (fch >= 8'h61) && (fch <= 8'h7a);

    logic walk_on, walk_char;
    assign walk_on   = (r_failed == 2'd0) && (r_cidx <= LVL_W'(MAX_DEPTH));
    assign walk_char = walk_on && (r_cidx < LVL_W'(MAX_DEPTH));

    logic [CHILD_AW-1:0] slot;
    assign slot = CHILD_AW'(r_pos) * CHILD_AW'(ALPHABET) + CHILD_AW'(r_j);

    logic [LVL_W-1:0] g_lvl;
    assign g_lvl = info_rdata[INFO_W-1 -: LVL_W];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == CHILD_AW'(CHILD_DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_s_tuser[0]) begin
                        n_state = (ID_W'(wid) >= r_count) ? S_OUT : S_G_RD;
                    end else if (walk_char && is_letter) begin
                        n_state = S_C_RD;
                    end else if (i_s_tlast) begin
                        n_state = S_M_RD;
                    end
                end
            end
            S_C_RD:   n_state = S_C_EVAL;
            S_C_EVAL: n_state = r_last ? S_M_RD : S_IDLE;
            S_M_RD:   n_state = S_M_EVAL;
            S_M_EVAL: n_state = S_OUT;
            S_G_RD:   n_state = S_G_EVAL;
            S_G_EVAL: n_state = S_OUT;
            S_OUT: begin
                if (i_m_tready) n_state = r_olast ? S_IDLE : S_G_RD;
            end
            default:  n_state = S_CLEAR;
        endcase
    end

    // Outputs and memory controls
    always_comb begin
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        c_we       = 1'b0;
        c_waddr    = r_slot;
        c_wdata    = r_count + ID_W'(1);
        c_raddr    = slot;
        m_we       = 1'b0;
        m_waddr    = MARK_AW'(r_pos);
        m_wdata    = 1'b1;
        i_we_info  = 1'b0;
        info_raddr = r_n[NODE_AW-1:0];
        info_wdata = {r_cidx, r_pos, r_j};
        case (r_state)
            S_CLEAR: begin
                c_we    = 1'b1;
                c_waddr = r_clr;
                c_wdata = '0;
                m_we    = (r_clr < CHILD_AW'(MARK_DEPTH));
                m_waddr = MARK_AW'(r_clr);
                m_wdata = 1'b0;
            end
            S_IDLE:   o_s_tready = 1'b1;
            S_C_EVAL: begin
                if (c_rdata == '0 && r_ins && r_count < ID_W'(MAX_NODES)) begin
                    c_we      = 1'b1;
                    i_we_info = 1'b1;
                end
            end
            S_M_EVAL: begin
                m_we = (r_failed == 2'd0) && (r_cidx <= LVL_W'(MAX_DEPTH))
                    && (m_rdata || r_ins);
            end
            S_OUT:    o_m_tvalid = 1'b1;
            default: begin
            end
        endcase
    end

    twid_ram #(.WIDTH(ID_W), .DEPTH(CHILD_DEPTH)) u_child (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr), .i_wdata(c_wdata),
        .i_raddr(c_raddr), .o_rdata(c_rdata)
    );

    twid_ram #(.WIDTH(1), .DEPTH(MARK_DEPTH)) u_mark (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_waddr), .i_wdata(m_wdata),
        .i_raddr(MARK_AW'(r_pos)), .o_rdata(m_rdata)
    );

    twid_ram #(.WIDTH(INFO_W), .DEPTH(MAX_NODES)) u_info (
        .i_clk(i_clk), .i_we(i_we_info), .i_waddr(r_count[NODE_AW-1:0]),
        .i_wdata(info_wdata), .i_raddr(info_raddr), .o_rdata(info_rdata)
    );

    // State and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_count  <= '0;
            r_pos    <= ID_W'(MAX_NODES);
            r_failed <= '0;
            r_cidx   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_CLEAR: r_clr <= r_clr + CHILD_AW'(1);
                S_IDLE: begin
                    if (accept) begin
                        r_last <= i_s_tlast;
                        r_ins  <= i_s_tuser[1];
                        r_j    <= LETTER_W'(fch - 8'h61);
                        r_n    <= ID_W'(wid);
                        if (i_s_tuser[0]) begin
                            // Bad id answers at once
                            r_status <= ST_BAD_ID;
                            r_id     <= '0;
                            r_letter <= '0;
                            r_lpos   <= '0;
                            r_olast  <= 1'b1;
                        end else if (walk_on) begin
                            r_cidx <= r_cidx + LVL_W'(1);
                            if (walk_char && !is_letter) r_failed <= 2'(ST_BAD_CHAR);
                        end
                    end
                end
                S_C_RD: r_slot <= slot;
                S_C_EVAL: begin
                    if (c_rdata != '0) begin
                        r_pos <= c_rdata - ID_W'(1);
                    end else if (!r_ins) begin
                        r_failed <= 2'(ST_NOT_FOUND);
                    end else if (r_count >= ID_W'(MAX_NODES)) begin
                        r_failed <= 2'(ST_FULL);
                    end else begin
                        r_pos   <= r_count;
                        r_count <= r_count + ID_W'(1);
                    end
                end
                S_M_EVAL: begin
                    r_id     <= '0;
                    r_letter <= '0;
                    r_lpos   <= '0;
                    r_olast  <= 1'b1;
                    if (r_failed != 2'd0) begin
                        r_status <= {1'b0, r_failed};
                    end else if (r_cidx > LVL_W'(MAX_DEPTH)) begin
                        r_status <= ST_TOO_LONG;
                    end else if (!m_rdata && !r_ins) begin
                        r_status <= ST_NOT_FOUND;
                    end else begin
                        r_status <= ST_OK;
                        r_id     <= r_pos[9:0];
                    end
                    r_pos    <= ID_W'(MAX_NODES);
                    r_failed <= '0;
                    r_cidx   <= '0;
                end
                S_G_EVAL: begin
                    // One letter per node, then step to the parent
                    r_status <= ST_OK;
                    r_id     <= '0;
                    r_letter <= 7'h61 + 7'(info_rdata[LETTER_W-1:0]);
                    r_lpos   <= 5'(g_lvl - LVL_W'(1));
                    r_olast  <= (g_lvl <= LVL_W'(1));
                    r_n      <= info_rdata[LETTER_W +: ID_W];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_m_tdata = {2'b00, r_lpos, r_letter, r_id};
    assign o_m_tlast = r_olast;
    assign o_m_tuser = r_status;

    // Checks
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid)) else $error("ready while result pending");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_s_tlast || i_s_tuser[0]) |=> !o_s_tready)
        else $error("second beat taken while busy");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ID_W'(MAX_NODES)) else $error("node count overflow");
    a_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos == ID_W'(MAX_NODES)) || (r_pos < r_count)) else $error("walk off table");

endmodule

[sv/twid_ram.sv]
module twid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[verif/trie_word_id_dictionary_test.sv]
`timescale 1ns / 1ps

module trie_word_id_dictionary_test;
    import twid_pkg::*;

    localparam bit REQ_CHAR = 1'b0;
    localparam bit REQ_GET  = 1'b1;
    localparam int NODE_LIMIT = 1024;
    localparam int DEPTH_LIMIT = 32;
    localparam int ROOT = NODE_LIMIT;

    // One beat of the result stream, split into its fields.
    typedef struct {
        t_status    status;
        logic [9:0] node_id;
        logic [6:0] letter;
        logic [4:0] letter_pos;
        logic       last_out;
    } dict_result_t;

    // Scoreboard: keeps its own copy of the trie and the answers it owes.
    class dict_scoreboard;
        int unsigned child [0:(NODE_LIMIT + 1) * 26 - 1];
        int unsigned letter_of [0:NODE_LIMIT - 1];
        int unsigned parent_of [0:NODE_LIMIT - 1];
        int unsigned level_of [0:NODE_LIMIT - 1];
        bit          word_end [0:NODE_LIMIT];
        int unsigned node_count;
        int unsigned walk_node;
        int unsigned walk_fail;
        int unsigned char_count;
        dict_result_t answers [$];
        int errors;

        function void clear();
            foreach (child[i]) child[i] = 0;
            foreach (word_end[i]) word_end[i] = 0;
            node_count = 0;
            walk_node = ROOT;
            walk_fail = 0;
            char_count = 0;
            errors = 0;
        endfunction

        function void owe(t_status st, int unsigned id, int unsigned ltr,
                          int unsigned pos, bit last);
            dict_result_t r;
            r.status = st;
            r.node_id = 10'(id);
            r.letter = 7'(ltr);
            r.letter_pos = 5'(pos);
            r.last_out = last;
            answers.push_back(r);
        endfunction

        // Follow or create the child for one character of the word in progress.
        function void walk_step(logic [7:0] ch, bit ins);
            int unsigned j;
            int unsigned slot;
            if (ch >= "A" && ch <= "Z") ch = ch - "A" + "a";
            if (ch < "a" || ch > "z") begin
                walk_fail = ST_BAD_CHAR;
                return;
            end
            j = ch - "a";
            slot = walk_node * 26 + j;
            if (child[slot] == 0) begin
                if (!ins) begin
                    walk_fail = ST_NOT_FOUND;
                    return;
                end
                if (node_count >= NODE_LIMIT) begin
                    walk_fail = ST_FULL;
                    return;
                end
                letter_of[node_count] = j;
                parent_of[node_count] = walk_node;
                level_of[node_count] = char_count;
                child[slot] = node_count + 1;
                node_count++;
            end
            walk_node = child[slot] - 1;
        endfunction

        // Called for every accepted input beat.
        function void note_request(bit req, logic [7:0] ch, bit last, bit ins,
                                   logic [9:0] wid);
            int unsigned n;
            int unsigned lvl;
            int k;
            if (req == REQ_GET) begin
                if (wid >= node_count) begin
                    owe(ST_BAD_ID, 0, 0, 0, 1);
                    return;
                end
                n = wid;
                lvl = level_of[n];
                k = 0;
                while (lvl > 0 && n < NODE_LIMIT && k < DEPTH_LIMIT) begin
                    owe(ST_OK, 0, "a" + letter_of[n], lvl - 1, lvl == 1);
                    k++;
                    n = parent_of[n];
                    lvl--;
                end
                if (k == 0) owe(ST_BAD_ID, 0, 0, 0, 1);
                else answers[answers.size() - 1].last_out = 1'b1;
                return;
            end
            if (walk_fail == 0 && char_count <= DEPTH_LIMIT) begin
                char_count++;
                if (char_count <= DEPTH_LIMIT) walk_step(ch, ins);
            end
            if (!last) return;
            if (walk_fail != 0) owe(t_status'(walk_fail), 0, 0, 0, 1);
            else if (char_count > DEPTH_LIMIT) owe(ST_TOO_LONG, 0, 0, 0, 1);
            else if (!word_end[walk_node] && !ins) owe(ST_NOT_FOUND, 0, 0, 0, 1);
            else begin
                word_end[walk_node] = 1'b1;
                owe(ST_OK, walk_node, 0, 0, 1);
            end
            walk_node = ROOT;
            walk_fail = 0;
            char_count = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Called for every accepted output beat.
        task check_result(dict_result_t got);
            dict_result_t want;
            if (answers.size() == 0) begin
                report($sformatf("unexpected beat status %0d id %0d letter %0d pos %0d",
                                 got.status, got.node_id, got.letter, got.letter_pos));
                return;
            end
            want = answers.pop_front();
            if (got.status !== want.status || got.node_id !== want.node_id ||
                got.letter !== want.letter || got.letter_pos !== want.letter_pos ||
                got.last_out !== want.last_out)
                report($sformatf({"got st %0d id %0d let %0d pos %0d last %0b, ",
                                  "want st %0d id %0d let %0d pos %0d last %0b"},
                                 got.status, got.node_id, got.letter, got.letter_pos,
                                 got.last_out, want.status, want.node_id, want.letter,
                                 want.letter_pos, want.last_out));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [23:0] i_s_tdata;   // char_byte [7:0], word_id [17:8], zero fill
    logic        i_s_tlast;   // last_char
    logic [1:0]  i_s_tuser;   // req_type [0], insert_mode [1]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;   // node_id [9:0], letter [16:10], letter_pos [21:17]
    logic        o_m_tlast;   // last_out
    logic [2:0]  o_m_tuser;   // status

    dict_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_req;
    int hold_left;
    int wait_cycles;

    trie_word_id_dictionary dut (.*);

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Receiver: random back-pressure, plus one long hold-off when asked.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0) hold_left--;
        i_m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Result monitor.
    always @(posedge i_clk) begin
        dict_result_t got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.status = t_status'(o_m_tuser);
            got.node_id = o_m_tdata[9:0];
            got.letter = o_m_tdata[16:10];
            got.letter_pos = o_m_tdata[21:17];
            got.last_out = o_m_tlast;
            sb.check_result(got);
        end
    end

    // Offer one beat and hold it until the block takes it.
    task send_beat(bit req, logic [7:0] ch, bit last, bit ins, logic [9:0] wid);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {6'd0, wid, ch};
        i_s_tlast <= last;
        i_s_tuser <= {ins, req};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_request(req, ch, last, ins, wid);
        @(negedge i_clk);
    endtask

    task send_word(string w, bit ins);
        for (int i = 0; i < w.len(); i++)
            send_beat(REQ_CHAR, w[i], i == w.len() - 1, ins, 10'($urandom_range(0, 1023)));
    endtask

    task send_get(int unsigned id);
        send_beat(REQ_GET, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 10'(id));
    endtask

    // Letters from a narrow alphabet so that lookups often hit, in either case.
    function logic [7:0] pick_letter(int span);
        logic [7:0] c;
        c = 8'("a" + $urandom_range(0, span));
        if ($urandom_range(0, 3) == 0) c = c - "a" + "A";
        return c;
    endfunction

    task send_random_word(int len, int span, bit ins);
        for (int i = 0; i < len; i++)
            send_beat(REQ_CHAR, pick_letter(span), i == len - 1, ins,
                      10'($urandom_range(0, 1023)));
    endtask

    // One random request, mostly well-formed words with random content.
    task random_request();
        int r;
        int len;
        r = $urandom_range(0, 99);
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 5);
        if (r < 60) begin
            send_random_word(len, 4, $urandom_range(0, 2) == 0);
        end else if (r < 75) begin
            if ($urandom_range(0, 4) == 0) send_get($urandom_range(0, 1023));
            else send_get($urandom_range(0, sb.node_count + 1));
        end else if (r < 85) begin
            // Get-word in the middle of a word must not disturb the walk.
            send_beat(REQ_CHAR, pick_letter(4), 1'b0, 1'b1, 10'($urandom_range(0, 1023)));
            send_get($urandom_range(0, sb.node_count));
            send_beat(REQ_CHAR, pick_letter(4), 1'b1, 1'b1, 10'($urandom_range(0, 1023)));
        end else begin
            send_beat(REQ_CHAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)));
        end
    endtask

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        sb = new();
        sb.clear();
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tlast = 1'b0;
        i_s_tuser = '0;
        i_m_tready = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        send_idle_pct = 9;
        recv_idle_pct = 69;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, case folding, failures and get-word.
        send_word("a", 1'b1);
        send_word("A", 1'b0);
        send_word("b", 1'b0);
        send_word("zZ", 1'b1);
        send_word("z", 1'b0);
        send_get(0);
        send_get(2);
        send_get(1023);
        send_beat(REQ_CHAR, 8'h00, 1'b1, 1'b1, 10'd0);
        send_beat(REQ_CHAR, "a", 1'b0, 1'b1, 10'h3ff);
        send_beat(REQ_CHAR, 8'hff, 1'b0, 1'b1, 10'h3ff);
        send_beat(REQ_CHAR, "a", 1'b1, 1'b1, 10'h3ff);
        send_beat(REQ_CHAR, "z", 1'b0, 1'b0, 10'd0);
        send_get(1);
        send_beat(REQ_CHAR, "z", 1'b1, 1'b0, 10'd0);
        send_beat(REQ_CHAR, "@", 1'b1, 1'b0, 10'd0);
        send_beat(REQ_CHAR, "{", 1'b1, 1'b0, 10'd0);

        for (int i = 0; i < 35; i++) random_request();

        // Long receiver hold-off while the sender keeps offering.
        send_idle_pct = 69;
        recv_idle_pct = 9;
        hold_req = 1'b1;
        for (int i = 0; i < 35; i++) random_request();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 35; i++) random_request();

        // An overlong insert, then get-word at the edges of the id range.
        send_random_word(34, 25, 1'b1);
        send_get(1023);
        send_get(NODE_LIMIT - 2);
        send_get($urandom_range(0, 1023));
        i_s_tvalid <= 1'b0;

        wait_cycles = 0;
        while (sb.answers.size() != 0 && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (200) @(posedge i_clk);
        if (sb.answers.size() != 0)
            sb.report($sformatf("%0d expected beats never arrived", sb.answers.size()));
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
